// ===== rtl/vmbrf_pkg.sv =====
// Package for the virtio-mmio block register file: item and result types,
// register offsets, identification constants and transaction codes.
// No dependencies; used by every other file of the block.
package vmbrf_pkg;

   // Field widths
   localparam int unsigned TYPE_WIDTH   = 2;
   localparam int unsigned OFFS_WIDTH   = 12;
   localparam int unsigned WORD_WIDTH   = 32;
   localparam int unsigned ADDR_WIDTH   = 64;
   localparam int unsigned CAP_WIDTH    = 48;
   localparam int unsigned CSR_IDX_WIDTH = 1;

   // Transaction kinds
   localparam logic [TYPE_WIDTH-1:0] REQ_READ     = 2'd0;
   localparam logic [TYPE_WIDTH-1:0] REQ_WRITE    = 2'd1;
   localparam logic [TYPE_WIDTH-1:0] REQ_COMPLETE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFFERED  = 1'd1;

   // Identification and fixed values
   localparam logic [WORD_WIDTH-1:0] MAGIC_VALUE    = 32'h7472_6976;
   localparam logic [WORD_WIDTH-1:0] VERSION_VALUE  = 32'd2;
   localparam logic [WORD_WIDTH-1:0] DEVICE_ID      = 32'd2;
   localparam logic [WORD_WIDTH-1:0] VENDOR_ID      = 32'h554d_4551;
   localparam logic [WORD_WIDTH-1:0] MAX_QUEUE_SIZE = 32'd128;
   localparam logic [WORD_WIDTH-1:0] SEG_MAX        = 32'd128;
   localparam logic [WORD_WIDTH-1:0] BLK_SIZE       = 32'd512;
   localparam int unsigned           FEATURES_OK    = 3;
   localparam logic [ADDR_WIDTH-1:0] OFFERED_RESET  = 64'h0000_0001_0000_0000;

   // Register offsets
   localparam logic [OFFS_WIDTH-1:0] OFF_MAGIC       = 12'h000;
   localparam logic [OFFS_WIDTH-1:0] OFF_VERSION     = 12'h004;
   localparam logic [OFFS_WIDTH-1:0] OFF_DEVICE_ID   = 12'h008;
   localparam logic [OFFS_WIDTH-1:0] OFF_VENDOR_ID   = 12'h00c;
   localparam logic [OFFS_WIDTH-1:0] OFF_DEV_FEAT    = 12'h010;
   localparam logic [OFFS_WIDTH-1:0] OFF_DEV_FEAT_SEL = 12'h014;
   localparam logic [OFFS_WIDTH-1:0] OFF_DRV_FEAT    = 12'h020;
   localparam logic [OFFS_WIDTH-1:0] OFF_DRV_FEAT_SEL = 12'h024;
   localparam logic [OFFS_WIDTH-1:0] OFF_QUEUE_SEL   = 12'h030;
   localparam logic [OFFS_WIDTH-1:0] OFF_QUEUE_MAX   = 12'h034;
   localparam logic [OFFS_WIDTH-1:0] OFF_QUEUE_NUM   = 12'h038;
   localparam logic [OFFS_WIDTH-1:0] OFF_QUEUE_READY = 12'h044;
   localparam logic [OFFS_WIDTH-1:0] OFF_QUEUE_NOTIFY = 12'h050;
   localparam logic [OFFS_WIDTH-1:0] OFF_IRQ_STATUS  = 12'h060;
   localparam logic [OFFS_WIDTH-1:0] OFF_IRQ_ACK     = 12'h064;
   localparam logic [OFFS_WIDTH-1:0] OFF_STATUS      = 12'h070;
   localparam logic [OFFS_WIDTH-1:0] OFF_DESC_LO     = 12'h080;
   localparam logic [OFFS_WIDTH-1:0] OFF_DESC_HI     = 12'h084;
   localparam logic [OFFS_WIDTH-1:0] OFF_AVAIL_LO    = 12'h090;
   localparam logic [OFFS_WIDTH-1:0] OFF_AVAIL_HI    = 12'h094;
   localparam logic [OFFS_WIDTH-1:0] OFF_USED_LO     = 12'h0a0;
   localparam logic [OFFS_WIDTH-1:0] OFF_USED_HI     = 12'h0a4;
   localparam logic [OFFS_WIDTH-1:0] OFF_CONFIG_GEN  = 12'h0fc;
   localparam logic [OFFS_WIDTH-1:0] OFF_CAP_LO      = 12'h100;
   localparam logic [OFFS_WIDTH-1:0] OFF_CAP_HI      = 12'h104;
   localparam logic [OFFS_WIDTH-1:0] OFF_SIZE_MAX    = 12'h108;
   localparam logic [OFFS_WIDTH-1:0] OFF_SEG_MAX     = 12'h10c;
   localparam logic [OFFS_WIDTH-1:0] OFF_BLK_SIZE    = 12'h114;

   // One incoming transaction
   typedef struct packed {
      logic [TYPE_WIDTH-1:0] req_type;
      logic [OFFS_WIDTH-1:0] reg_offset;
      logic [WORD_WIDTH-1:0] write_data;
   } item_type;

   // One result transaction
   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_data;
      logic                  doorbell;
      logic                  ring_reset;
      logic                  irq_line;
      logic [WORD_WIDTH-1:0] ring_size;
      logic [ADDR_WIDTH-1:0] ring_desc_base;
      logic [ADDR_WIDTH-1:0] ring_avail_base;
      logic [ADDR_WIDTH-1:0] ring_used_base;
   } result_type;

   // Device configuration held outside the register core
   typedef struct packed {
      logic [CAP_WIDTH-1:0]  disk_sectors;
      logic [ADDR_WIDTH-1:0] offered_features;
   } dev_cfg_type;

endpackage

// ===== rtl/vmbrf_if.sv =====
// Valid/ready channel interfaces for the register file's request and
// response sides. Depends on vmbrf_pkg for field widths.
interface vmbrf_req_if;
   logic                                valid;
   logic                                ready;
   logic [vmbrf_pkg::TYPE_WIDTH-1:0]    req_type;
   logic [vmbrf_pkg::OFFS_WIDTH-1:0]    reg_offset;
   logic [vmbrf_pkg::WORD_WIDTH-1:0]    write_data;

   modport source (output valid, output req_type, output reg_offset,
                   output write_data, input ready);
   modport sink   (input valid, input req_type, input reg_offset,
                   input write_data, output ready);
endinterface

interface vmbrf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [vmbrf_pkg::WORD_WIDTH-1:0]    read_data;
   logic                                doorbell;
   logic                                ring_reset;
   logic                                irq_line;
   logic [vmbrf_pkg::WORD_WIDTH-1:0]    ring_size;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0]    ring_desc_base;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0]    ring_avail_base;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0]    ring_used_base;

   modport source (output valid, output read_data, output doorbell,
                   output ring_reset, output irq_line, output ring_size,
                   output ring_desc_base, output ring_avail_base,
                   output ring_used_base, input ready);
   modport sink   (input valid, input read_data, input doorbell,
                   input ring_reset, input irq_line, input ring_size,
                   input ring_desc_base, input ring_avail_base,
                   input ring_used_base, output ready);
endinterface

// ===== rtl/vmbrf_regs.sv =====
// Register core: device state, read decode and write side effects.
// Produces the result of one transaction combinationally and commits the
// state update on commit. Depends on vmbrf_pkg.
module vmbrf_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  vmbrf_pkg::dev_cfg_type  dev_cfg,
   input  vmbrf_pkg::item_type     item,
   input  logic                    commit,
   output vmbrf_pkg::result_type   result
);

   localparam int unsigned W = vmbrf_pkg::WORD_WIDTH;
   localparam int unsigned A = vmbrf_pkg::ADDR_WIDTH;

   logic [W-1:0] dev_sel_ff,  dev_sel_in;
   logic [W-1:0] drv_sel_ff,  drv_sel_in;
   logic [A-1:0] accepted_ff, accepted_in;
   logic [W-1:0] queue_sel_ff, queue_sel_in;
   logic [W-1:0] queue_len_ff, queue_len_in;
   logic         queue_rdy_ff, queue_rdy_in;
   logic [A-1:0] desc_ff,     desc_in;
   logic [A-1:0] avail_ff,    avail_in;
   logic [A-1:0] used_ff,     used_in;
   logic [W-1:0] status_ff,   status_in;
   logic [W-1:0] pending_ff,  pending_in;

   logic         q0;
   logic [W-1:0] rd_data;
   logic         bell;
   logic         rst_pulse;
   logic [W-1:0] status_set;
   logic [W-1:0] wdata;
   logic [W-1:0] cap_hi;

   assign q0     = (queue_sel_ff == '0);
   assign wdata  = item.write_data;
   assign cap_hi = {{(W - (vmbrf_pkg::CAP_WIDTH - W)){1'b0}},
                    dev_cfg.disk_sectors[vmbrf_pkg::CAP_WIDTH-1:W]};

   // Read decode, from the state before this transaction
   always_comb begin
      rd_data = '0;
      case (item.reg_offset)
         vmbrf_pkg::OFF_MAGIC:        rd_data = vmbrf_pkg::MAGIC_VALUE;
         vmbrf_pkg::OFF_VERSION:      rd_data = vmbrf_pkg::VERSION_VALUE;
         vmbrf_pkg::OFF_DEVICE_ID:    rd_data = vmbrf_pkg::DEVICE_ID;
         vmbrf_pkg::OFF_VENDOR_ID:    rd_data = vmbrf_pkg::VENDOR_ID;
         vmbrf_pkg::OFF_DEV_FEAT: begin
            if (dev_sel_ff == 32'd0) begin
               rd_data = dev_cfg.offered_features[W-1:0];
            end else if (dev_sel_ff == 32'd1) begin
               rd_data = dev_cfg.offered_features[A-1:W];
            end
         end
         vmbrf_pkg::OFF_DEV_FEAT_SEL: rd_data = dev_sel_ff;
         vmbrf_pkg::OFF_QUEUE_SEL:    rd_data = queue_sel_ff;
         vmbrf_pkg::OFF_QUEUE_MAX:    rd_data = q0 ? vmbrf_pkg::MAX_QUEUE_SIZE : '0;
         vmbrf_pkg::OFF_QUEUE_NUM:    rd_data = q0 ? queue_len_ff : '0;
         vmbrf_pkg::OFF_QUEUE_READY:  rd_data = {{(W-1){1'b0}}, q0 & queue_rdy_ff};
         vmbrf_pkg::OFF_IRQ_STATUS:   rd_data = pending_ff;
         vmbrf_pkg::OFF_STATUS:       rd_data = status_ff;
         vmbrf_pkg::OFF_DESC_LO:      rd_data = q0 ? desc_ff[W-1:0]  : '0;
         vmbrf_pkg::OFF_DESC_HI:      rd_data = q0 ? desc_ff[A-1:W]  : '0;
         vmbrf_pkg::OFF_AVAIL_LO:     rd_data = q0 ? avail_ff[W-1:0] : '0;
         vmbrf_pkg::OFF_AVAIL_HI:     rd_data = q0 ? avail_ff[A-1:W] : '0;
         vmbrf_pkg::OFF_USED_LO:      rd_data = q0 ? used_ff[W-1:0]  : '0;
         vmbrf_pkg::OFF_USED_HI:      rd_data = q0 ? used_ff[A-1:W]  : '0;
         vmbrf_pkg::OFF_CONFIG_GEN:   rd_data = '0;
         vmbrf_pkg::OFF_CAP_LO:       rd_data = dev_cfg.disk_sectors[W-1:0];
         vmbrf_pkg::OFF_CAP_HI:       rd_data = cap_hi;
         vmbrf_pkg::OFF_SIZE_MAX:     rd_data = '0;
         vmbrf_pkg::OFF_SEG_MAX:      rd_data = vmbrf_pkg::SEG_MAX;
         vmbrf_pkg::OFF_BLK_SIZE:     rd_data = vmbrf_pkg::BLK_SIZE;
         default:                     rd_data = '0;
      endcase
   end

   // Status write: set bits, then drop FEATURES_OK if unoffered features are accepted
   always_comb begin
      status_set = status_ff | wdata;
      if (status_set[vmbrf_pkg::FEATURES_OK] &&
          ((accepted_ff & ~dev_cfg.offered_features) != '0)) begin
         status_set[vmbrf_pkg::FEATURES_OK] = 1'b0;
      end
   end

   // Next state and write side effects
   always_comb begin
      dev_sel_in   = dev_sel_ff;
      drv_sel_in   = drv_sel_ff;
      accepted_in  = accepted_ff;
      queue_sel_in = queue_sel_ff;
      queue_len_in = queue_len_ff;
      queue_rdy_in = queue_rdy_ff;
      desc_in      = desc_ff;
      avail_in     = avail_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      pending_in   = pending_ff;
      bell         = 1'b0;
      rst_pulse    = 1'b0;
      case (item.req_type)
         vmbrf_pkg::REQ_WRITE: begin
            case (item.reg_offset)
               vmbrf_pkg::OFF_DEV_FEAT_SEL: dev_sel_in = wdata;
               vmbrf_pkg::OFF_DRV_FEAT_SEL: drv_sel_in = wdata;
               vmbrf_pkg::OFF_DRV_FEAT: begin
                  if (drv_sel_ff == 32'd0) begin
                     accepted_in[W-1:0] = wdata;
                  end else if (drv_sel_ff == 32'd1) begin
                     accepted_in[A-1:W] = wdata;
                  end
               end
               vmbrf_pkg::OFF_QUEUE_SEL:   queue_sel_in = wdata;
               vmbrf_pkg::OFF_QUEUE_NUM:   if (q0) queue_len_in = wdata;
               vmbrf_pkg::OFF_QUEUE_READY: if (q0) queue_rdy_in = (wdata != '0);
               vmbrf_pkg::OFF_DESC_LO:     if (q0) desc_in[W-1:0]  = wdata;
               vmbrf_pkg::OFF_DESC_HI:     if (q0) desc_in[A-1:W]  = wdata;
               vmbrf_pkg::OFF_AVAIL_LO:    if (q0) avail_in[W-1:0] = wdata;
               vmbrf_pkg::OFF_AVAIL_HI:    if (q0) avail_in[A-1:W] = wdata;
               vmbrf_pkg::OFF_USED_LO:     if (q0) used_in[W-1:0]  = wdata;
               vmbrf_pkg::OFF_USED_HI:     if (q0) used_in[A-1:W]  = wdata;
               vmbrf_pkg::OFF_QUEUE_NOTIFY: begin
                  bell = (wdata == '0) && queue_rdy_ff && (queue_len_ff != '0);
               end
               vmbrf_pkg::OFF_IRQ_ACK:     pending_in = pending_ff & ~wdata;
               vmbrf_pkg::OFF_STATUS: begin
                  if (wdata == '0) begin
                     // device reset: everything back to zero
                     dev_sel_in   = '0;
                     drv_sel_in   = '0;
                     accepted_in  = '0;
                     queue_sel_in = '0;
                     queue_len_in = '0;
                     queue_rdy_in = 1'b0;
                     desc_in      = '0;
                     avail_in     = '0;
                     used_in      = '0;
                     status_in    = '0;
                     pending_in   = '0;
                     rst_pulse    = 1'b1;
                  end else begin
                     status_in = status_set;
                  end
               end
               default: ;
            endcase
         end
         vmbrf_pkg::REQ_COMPLETE: pending_in = pending_ff | {{(W-1){1'b0}}, 1'b1};
         default: ;
      endcase
   end

   // Result: read data from the state before this transaction, the rest from the state after it
   always_comb begin
      result.read_data       = (item.req_type == vmbrf_pkg::REQ_READ) ? rd_data : '0;
      result.doorbell        = bell;
      result.ring_reset      = rst_pulse;
      result.irq_line        = (pending_in != '0);
      result.ring_size       = queue_len_in;
      result.ring_desc_base  = desc_in;
      result.ring_avail_base = avail_in;
      result.ring_used_base  = used_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_sel_ff   <= '0;
         drv_sel_ff   <= '0;
         accepted_ff  <= '0;
         queue_sel_ff <= '0;
         queue_len_ff <= '0;
         queue_rdy_ff <= 1'b0;
         desc_ff      <= '0;
         avail_ff     <= '0;
         used_ff      <= '0;
         status_ff    <= '0;
         pending_ff   <= '0;
      end else if (commit) begin
         dev_sel_ff   <= dev_sel_in;
         drv_sel_ff   <= drv_sel_in;
         accepted_ff  <= accepted_in;
         queue_sel_ff <= queue_sel_in;
         queue_len_ff <= queue_len_in;
         queue_rdy_ff <= queue_rdy_in;
         desc_ff      <= desc_in;
         avail_ff     <= avail_in;
         used_ff      <= used_in;
         status_ff    <= status_in;
         pending_ff   <= pending_in;
      end
   end

endmodule

// ===== rtl/virtio_mmio_block_register_file_unit.sv =====
// Top level of the virtio-mmio block register file: request/response
// pipeline, configuration registers and the register core.
// Depends on vmbrf_pkg, vmbrf_if.sv and vmbrf_regs.
//
// Usage:
//  req  - register read, register write or queue-engine completion; one
//         transaction per valid/ready handshake.
//  rsp  - exactly one result per request, in order: read data (zero for
//         writes and completions), doorbell and ring_reset pulses, the
//         interrupt line and the current queue 0 ring settings.
//  csr  - capacity (index 0) and offered features (index 1); write only
//         while no transaction is in flight.
// Path: an accepted request enters the request register, its result then the
//  response register. Throughput: one transaction per cycle while rsp.ready
//  is high; the state update sits in one stage between the two registers.
// Reset (synchronous): all device state clears, offered features return
//  to VERSION_1 only, capacity to zero, both stages empty.
// Stall: while rsp.ready is low the response holds and one more request
//  is taken into the request register; req.ready then drops.
module virtio_mmio_block_register_file_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   vmbrf_req_if.sink                              req,
   vmbrf_rsp_if.source                            rsp,
   input  logic                                   csr_write_enable,
   input  logic [vmbrf_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [vmbrf_pkg::ADDR_WIDTH-1:0]       csr_write_data
);

   vmbrf_pkg::dev_cfg_type cfg_ff, cfg_in;

   logic                  s0_valid_ff, s0_valid_in;
   vmbrf_pkg::item_type   s0_item_ff,  s0_item_in;
   logic                  out_valid_ff, out_valid_in;
   vmbrf_pkg::result_type out_ff, out_in;

   vmbrf_pkg::item_type   req_item;
   vmbrf_pkg::result_type core_result;
   logic                  out_take;
   logic                  s0_fire;
   logic                  req_accept;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            vmbrf_pkg::CSR_CAPACITY:
               cfg_in.disk_sectors = csr_write_data[vmbrf_pkg::CAP_WIDTH-1:0];
            vmbrf_pkg::CSR_OFFERED:
               cfg_in.offered_features = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_sectors     <= '0;
         cfg_ff.offered_features <= vmbrf_pkg::OFFERED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake control
   assign out_take   = !out_valid_ff || rsp.ready;
   assign s0_fire    = s0_valid_ff && out_take;
   assign req.ready  = !s0_valid_ff || out_take;
   assign req_accept = req.valid && req.ready;

   assign req_item.req_type   = req.req_type;
   assign req_item.reg_offset = req.reg_offset;
   assign req_item.write_data = req.write_data;

   always_comb begin
      s0_valid_in  = req.ready ? req.valid : s0_valid_ff;
      s0_item_in   = req_accept ? req_item : s0_item_ff;
      out_valid_in = out_take ? s0_valid_ff : out_valid_ff;
      out_in       = s0_fire ? core_result : out_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s0_item_ff <= s0_item_in;
      out_ff     <= out_in;
   end

   vmbrf_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .dev_cfg (cfg_ff),
      .item    (s0_item_ff),
      .commit  (s0_fire),
      .result  (core_result)
   );

   // Response channel
   assign rsp.valid           = out_valid_ff;
   assign rsp.read_data       = out_ff.read_data;
   assign rsp.doorbell        = out_ff.doorbell;
   assign rsp.ring_reset      = out_ff.ring_reset;
   assign rsp.irq_line        = out_ff.irq_line;
   assign rsp.ring_size       = out_ff.ring_size;
   assign rsp.ring_desc_base  = out_ff.ring_desc_base;
   assign rsp.ring_avail_base = out_ff.ring_avail_base;
   assign rsp.ring_used_base  = out_ff.ring_used_base;

endmodule

// ===== rtl/vmbrf_checker.sv =====
// Port-level checks of the register file's response channel, and the bind
// that attaches them to the top level. Depends on vmbrf_pkg.
module vmbrf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              doorbell,
   input logic                              ring_reset,
   input logic                              irq_line,
   input logic [vmbrf_pkg::WORD_WIDTH-1:0]  ring_size,
   input logic [vmbrf_pkg::ADDR_WIDTH-1:0]  ring_desc_base,
   input logic [vmbrf_pkg::ADDR_WIDTH-1:0]  ring_avail_base,
   input logic [vmbrf_pkg::ADDR_WIDTH-1:0]  ring_used_base
);

   // A device reset leaves the queue and interrupts cleared
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ring_reset |-> ring_size == '0 && ring_desc_base == '0 &&
         ring_avail_base == '0 && ring_used_base == '0 && !irq_line)
      else $error("ring_reset with queue state not cleared");

   // Doorbell only rings for a non-empty queue
   a_bell_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && doorbell |-> ring_size != '0)
      else $error("doorbell with zero queue size");

   // One transaction cannot both notify and reset
   a_bell_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(doorbell && ring_reset))
      else $error("doorbell and ring_reset together");

   // A stalled response stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind virtio_mmio_block_register_file_unit vmbrf_checker u_vmbrf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .doorbell        (rsp.doorbell),
   .ring_reset      (rsp.ring_reset),
   .irq_line        (rsp.irq_line),
   .ring_size       (rsp.ring_size),
   .ring_desc_base  (rsp.ring_desc_base),
   .ring_avail_base (rsp.ring_avail_base),
   .ring_used_base  (rsp.ring_used_base)
);

// ===== sim/virtio_mmio_block_register_file_unit_tb.sv =====
// Self-checking testbench for the virtio-mmio block register file: directed and
// random register traffic, in-order scoreboard against a behavioral shadow.
// Depends on rtl/vmbrf_pkg.sv, rtl/vmbrf_if.sv and the unit's RTL.
module virtio_mmio_block_register_file_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Transaction kind the block must ignore
   localparam logic [vmbrf_pkg::TYPE_WIDTH-1:0] REQ_SPARE = 2'd3;
   localparam int unsigned IDLE_LIMIT = 500;
   localparam int unsigned PHASE_ITEMS = 96;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                csr_write_enable;
   logic [vmbrf_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0]    csr_write_data;

   vmbrf_req_if req_ch ();
   vmbrf_rsp_if rsp_ch ();

   virtio_mmio_block_register_file_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the device state and its configuration
   logic [vmbrf_pkg::CAP_WIDTH-1:0]  cfg_capacity;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0] cfg_offered;
   logic [vmbrf_pkg::WORD_WIDTH-1:0] shadow_dev_sel, shadow_drv_sel, shadow_qsel, shadow_qnum;
   logic [vmbrf_pkg::WORD_WIDTH-1:0] shadow_status, shadow_isr;
   logic [vmbrf_pkg::ADDR_WIDTH-1:0] shadow_features, shadow_desc, shadow_avail, shadow_used;
   logic                             shadow_qready;

   vmbrf_pkg::item_type   pending_items[$];
   vmbrf_pkg::result_type expected_results[$];
   vmbrf_pkg::item_type   next_item;
   vmbrf_pkg::result_type observed;
   int unsigned errors = 0;
   int unsigned idle_cycles = 0;
   int unsigned queued_count = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic [15:0] stall_pattern = '1;

   function automatic void shadow_clear();
      shadow_dev_sel  = '0;
      shadow_drv_sel  = '0;
      shadow_features = '0;
      shadow_qsel     = '0;
      shadow_qnum     = '0;
      shadow_qready   = 1'b0;
      shadow_desc     = '0;
      shadow_avail    = '0;
      shadow_used     = '0;
      shadow_status   = '0;
      shadow_isr      = '0;
   endfunction

   // Apply one transaction to the shadow and return the response it produces
   function automatic vmbrf_pkg::result_type predict_access(vmbrf_pkg::item_type it);
      vmbrf_pkg::result_type r;
      logic q0;
      logic [vmbrf_pkg::WORD_WIDTH-1:0] v;
      r  = '0;
      v  = it.write_data;
      q0 = (shadow_qsel == 0);
      case (it.req_type)
         vmbrf_pkg::REQ_READ: begin
            case (it.reg_offset)
               vmbrf_pkg::OFF_MAGIC:        r.read_data = vmbrf_pkg::MAGIC_VALUE;
               vmbrf_pkg::OFF_VERSION:      r.read_data = vmbrf_pkg::VERSION_VALUE;
               vmbrf_pkg::OFF_DEVICE_ID:    r.read_data = vmbrf_pkg::DEVICE_ID;
               vmbrf_pkg::OFF_VENDOR_ID:    r.read_data = vmbrf_pkg::VENDOR_ID;
               vmbrf_pkg::OFF_DEV_FEAT: begin
                  if (shadow_dev_sel == 0) r.read_data = cfg_offered[31:0];
                  else if (shadow_dev_sel == 1) r.read_data = cfg_offered[63:32];
               end
               vmbrf_pkg::OFF_DEV_FEAT_SEL: r.read_data = shadow_dev_sel;
               vmbrf_pkg::OFF_QUEUE_SEL:    r.read_data = shadow_qsel;
               vmbrf_pkg::OFF_QUEUE_MAX:    r.read_data = q0 ? vmbrf_pkg::MAX_QUEUE_SIZE : '0;
               vmbrf_pkg::OFF_QUEUE_NUM:    r.read_data = q0 ? shadow_qnum : '0;
               vmbrf_pkg::OFF_QUEUE_READY:  r.read_data = {31'b0, q0 && shadow_qready};
               vmbrf_pkg::OFF_IRQ_STATUS:   r.read_data = shadow_isr;
               vmbrf_pkg::OFF_STATUS:       r.read_data = shadow_status;
               vmbrf_pkg::OFF_DESC_LO:      r.read_data = q0 ? shadow_desc[31:0] : '0;
               vmbrf_pkg::OFF_DESC_HI:      r.read_data = q0 ? shadow_desc[63:32] : '0;
               vmbrf_pkg::OFF_AVAIL_LO:     r.read_data = q0 ? shadow_avail[31:0] : '0;
               vmbrf_pkg::OFF_AVAIL_HI:     r.read_data = q0 ? shadow_avail[63:32] : '0;
               vmbrf_pkg::OFF_USED_LO:      r.read_data = q0 ? shadow_used[31:0] : '0;
               vmbrf_pkg::OFF_USED_HI:      r.read_data = q0 ? shadow_used[63:32] : '0;
               vmbrf_pkg::OFF_CAP_LO:       r.read_data = cfg_capacity[31:0];
               vmbrf_pkg::OFF_CAP_HI:       r.read_data = {16'b0, cfg_capacity[47:32]};
               vmbrf_pkg::OFF_SEG_MAX:      r.read_data = vmbrf_pkg::SEG_MAX;
               vmbrf_pkg::OFF_BLK_SIZE:     r.read_data = vmbrf_pkg::BLK_SIZE;
               default:                     r.read_data = '0;
            endcase
         end
         vmbrf_pkg::REQ_WRITE: begin
            case (it.reg_offset)
               vmbrf_pkg::OFF_DEV_FEAT_SEL: shadow_dev_sel = v;
               vmbrf_pkg::OFF_DRV_FEAT_SEL: shadow_drv_sel = v;
               vmbrf_pkg::OFF_DRV_FEAT: begin
                  if (shadow_drv_sel == 0) shadow_features[31:0] = v;
                  else if (shadow_drv_sel == 1) shadow_features[63:32] = v;
               end
               vmbrf_pkg::OFF_QUEUE_SEL:    shadow_qsel = v;
               vmbrf_pkg::OFF_QUEUE_NUM:    if (q0) shadow_qnum = v;
               vmbrf_pkg::OFF_QUEUE_READY:  if (q0) shadow_qready = (v != 0);
               vmbrf_pkg::OFF_DESC_LO:      if (q0) shadow_desc[31:0] = v;
               vmbrf_pkg::OFF_DESC_HI:      if (q0) shadow_desc[63:32] = v;
               vmbrf_pkg::OFF_AVAIL_LO:     if (q0) shadow_avail[31:0] = v;
               vmbrf_pkg::OFF_AVAIL_HI:     if (q0) shadow_avail[63:32] = v;
               vmbrf_pkg::OFF_USED_LO:      if (q0) shadow_used[31:0] = v;
               vmbrf_pkg::OFF_USED_HI:      if (q0) shadow_used[63:32] = v;
               vmbrf_pkg::OFF_QUEUE_NOTIFY:
                  r.doorbell = (v == 0) && shadow_qready && (shadow_qnum != 0);
               vmbrf_pkg::OFF_IRQ_ACK:      shadow_isr = shadow_isr & ~v;
               vmbrf_pkg::OFF_STATUS: begin
                  if (v == 0) begin
                     shadow_clear();
                     r.ring_reset = 1'b1;
                  end else begin
                     shadow_status = shadow_status | v;
                     // negotiation fails if the driver took a feature not offered
                     if (shadow_status[vmbrf_pkg::FEATURES_OK] &&
                         (shadow_features & ~cfg_offered) != 0)
                        shadow_status[vmbrf_pkg::FEATURES_OK] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         vmbrf_pkg::REQ_COMPLETE: shadow_isr[0] = 1'b1;
         default: ;
      endcase
      r.irq_line        = (shadow_isr != 0);
      r.ring_size       = shadow_qnum;
      r.ring_desc_base  = shadow_desc;
      r.ring_avail_base = shadow_avail;
      r.ring_used_base  = shadow_used;
      return r;
   endfunction

   task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_response(vmbrf_pkg::result_type want, vmbrf_pkg::result_type got);
      report_field("read_data", 64'(want.read_data), 64'(got.read_data));
      report_field("doorbell", 64'(want.doorbell), 64'(got.doorbell));
      report_field("ring_reset", 64'(want.ring_reset), 64'(got.ring_reset));
      report_field("irq_line", 64'(want.irq_line), 64'(got.irq_line));
      report_field("ring_size", 64'(want.ring_size), 64'(got.ring_size));
      report_field("ring_desc_base", want.ring_desc_base, got.ring_desc_base);
      report_field("ring_avail_base", want.ring_avail_base, got.ring_avail_base);
      report_field("ring_used_base", want.ring_used_base, got.ring_used_base);
   endtask

   // Monitor: score responses, predict accepted requests, watchdog
   always @(posedge clock) begin
      if (reset) begin
         shadow_clear();
         req_fire = 1'b0;
         rsp_fire = 1'b0;
         idle_cycles = 0;
      end else begin
         req_fire = req_ch.valid && req_ch.ready;
         rsp_fire = rsp_ch.valid && rsp_ch.ready;
         if (rsp_fire) begin
            observed = {rsp_ch.read_data, rsp_ch.doorbell, rsp_ch.ring_reset,
                        rsp_ch.irq_line, rsp_ch.ring_size, rsp_ch.ring_desc_base,
                        rsp_ch.ring_avail_base, rsp_ch.ring_used_base};
            if (expected_results.size() == 0) begin
               $display("%0t: response with nothing outstanding, expected none actual %h",
                        $time, observed);
               errors++;
            end else begin
               check_response(expected_results.pop_front(), observed);
            end
         end
         if (req_fire)
            expected_results.insert(expected_results.size(),
                                    predict_access({req_ch.req_type, req_ch.reg_offset,
                                                    req_ch.write_data}));
         if (req_fire || rsp_fire) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("virtio_mmio_block_register_file_unit_tb NOT OK");
            $finish;
         end
      end
   end

   // Request driver: bursts of random length separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else if (!req_ch.valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_ch.req_type   <= next_item.req_type;
            req_ch.reg_offset <= next_item.reg_offset;
            req_ch.write_data <= next_item.write_data;
            req_ch.valid      <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left--;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: rotating 16-bit pattern, reshuffled whenever stall_left runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = 64;
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
      end
      rsp_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      stall_left--;
   end

   task automatic add_item(logic [vmbrf_pkg::TYPE_WIDTH-1:0] kind,
                           logic [vmbrf_pkg::OFFS_WIDTH-1:0] offs,
                           logic [vmbrf_pkg::WORD_WIDTH-1:0] data);
      vmbrf_pkg::item_type it;
      it.req_type = kind;
      it.reg_offset = offs;
      it.write_data = data;
      pending_items.insert(pending_items.size(), it);
      queued_count++;
   endtask

   function automatic logic [vmbrf_pkg::WORD_WIDTH-1:0] rand_word();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 300);
         default: return $urandom;
      endcase
   endfunction

   // Single access anywhere in the window, mostly at defined offsets
   task automatic add_noise();
      logic [vmbrf_pkg::OFFS_WIDTH-1:0] offs;
      case ($urandom_range(0, 35))
         0:  offs = vmbrf_pkg::OFF_MAGIC;
         1:  offs = vmbrf_pkg::OFF_VERSION;
         2:  offs = vmbrf_pkg::OFF_DEVICE_ID;
         3:  offs = vmbrf_pkg::OFF_VENDOR_ID;
         4:  offs = vmbrf_pkg::OFF_DEV_FEAT;
         5:  offs = vmbrf_pkg::OFF_DEV_FEAT_SEL;
         6:  offs = vmbrf_pkg::OFF_DRV_FEAT;
         7:  offs = vmbrf_pkg::OFF_DRV_FEAT_SEL;
         8:  offs = vmbrf_pkg::OFF_QUEUE_SEL;
         9:  offs = vmbrf_pkg::OFF_QUEUE_MAX;
         10: offs = vmbrf_pkg::OFF_QUEUE_NUM;
         11: offs = vmbrf_pkg::OFF_QUEUE_READY;
         12: offs = vmbrf_pkg::OFF_QUEUE_NOTIFY;
         13: offs = vmbrf_pkg::OFF_IRQ_STATUS;
         14: offs = vmbrf_pkg::OFF_IRQ_ACK;
         15: offs = vmbrf_pkg::OFF_STATUS;
         16: offs = vmbrf_pkg::OFF_DESC_LO;
         17: offs = vmbrf_pkg::OFF_DESC_HI;
         18: offs = vmbrf_pkg::OFF_AVAIL_LO;
         19: offs = vmbrf_pkg::OFF_AVAIL_HI;
         20: offs = vmbrf_pkg::OFF_USED_LO;
         21: offs = vmbrf_pkg::OFF_USED_HI;
         22: offs = vmbrf_pkg::OFF_CONFIG_GEN;
         23: offs = vmbrf_pkg::OFF_CAP_LO;
         24: offs = vmbrf_pkg::OFF_CAP_HI;
         25: offs = vmbrf_pkg::OFF_SIZE_MAX;
         26: offs = vmbrf_pkg::OFF_SEG_MAX;
         27: offs = vmbrf_pkg::OFF_BLK_SIZE;
         default: offs = vmbrf_pkg::OFFS_WIDTH'($urandom_range(0, 4095));
      endcase
      add_item(vmbrf_pkg::TYPE_WIDTH'($urandom_range(0, 3)), offs, rand_word());
   endtask

   // Driver bring-up: status handshake, feature negotiation, queue setup
   task automatic add_bringup();
      logic [vmbrf_pkg::WORD_WIDTH-1:0] lo, hi;
      lo = ($urandom_range(0, 3) == 0) ? $urandom : cfg_offered[31:0] & $urandom;
      hi = ($urandom_range(0, 3) == 0) ? $urandom : cfg_offered[63:32] & $urandom;
      if ($urandom_range(0, 1) == 0) add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, 32'h1);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, 32'h3);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DEV_FEAT_SEL, '0);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_DEV_FEAT, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DEV_FEAT_SEL, 32'h1);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_DEV_FEAT, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT_SEL, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT, lo);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT_SEL, 32'h1);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT, hi);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, 32'hB);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_STATUS, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_SEL,
               ($urandom_range(0, 7) == 0) ? rand_word() : '0);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_QUEUE_MAX, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_NUM,
               ($urandom_range(0, 4) == 0) ? rand_word() :
                                             $urandom_range(1, vmbrf_pkg::MAX_QUEUE_SIZE));
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DESC_LO, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DESC_HI, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_AVAIL_LO, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_AVAIL_HI, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_USED_LO, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_USED_HI, $urandom);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_READY,
               ($urandom_range(0, 4) == 0) ? rand_word() : 32'h1);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, 32'hF);
   endtask

   // Running-queue traffic: notifies, completions, interrupt handling
   task automatic add_traffic();
      int unsigned n;
      n = $urandom_range(2, 8);
      repeat (n) begin
         case ($urandom_range(0, 7))
            0, 1: add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_NOTIFY,
                           ($urandom_range(0, 5) == 0) ? rand_word() : '0);
            2, 3: add_item(vmbrf_pkg::REQ_COMPLETE,
                           vmbrf_pkg::OFFS_WIDTH'($urandom_range(0, 4095)), $urandom);
            4:    add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_IRQ_STATUS, '0);
            5:    add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_IRQ_ACK,
                           $urandom_range(0, 1) ? 32'h1 : rand_word());
            6:    add_item(vmbrf_pkg::REQ_READ,
                           vmbrf_pkg::OFF_DESC_LO + 12'($urandom_range(0, 5) * 8), '0);
            default: add_item($urandom_range(0, 1) ? vmbrf_pkg::REQ_READ : vmbrf_pkg::REQ_WRITE,
                              vmbrf_pkg::OFF_QUEUE_NUM,
                              $urandom_range(0, 2 * vmbrf_pkg::MAX_QUEUE_SIZE));
         endcase
      end
   endtask

   // Block until every queued transaction has been answered
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_setting(logic [vmbrf_pkg::CSR_IDX_WIDTH-1:0] idx,
                                logic [vmbrf_pkg::ADDR_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == vmbrf_pkg::CSR_CAPACITY) cfg_capacity = value[vmbrf_pkg::CAP_WIDTH-1:0];
      else cfg_offered = value;
   endtask

   // Stimulus sequencing
   initial begin
      int unsigned phase_start, chunk_end;
      logic [vmbrf_pkg::ADDR_WIDTH-1:0] cap_val, feat_val;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = vmbrf_pkg::REQ_READ;
      req_ch.reg_offset = '0;
      req_ch.write_data = '0;
      rsp_ch.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = vmbrf_pkg::CSR_CAPACITY;
      csr_write_data    = '0;
      cfg_capacity      = '0;
      cfg_offered       = vmbrf_pkg::OFFERED_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed checks at reset configuration
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_MAGIC, '1);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_VENDOR_ID, '0);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_DEV_FEAT, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DEV_FEAT_SEL, 32'h1);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_DEV_FEAT, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DEV_FEAT_SEL, '1);  // select out of range
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_DEV_FEAT, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT_SEL, 32'h2);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT, '1);      // ignored
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT_SEL, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DRV_FEAT, 32'h1);   // feature not offered
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, 32'h8);     // FEATURES_OK drops
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_STATUS, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_NUM, '1);     // above max, kept
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_READY, 32'h1);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_NOTIFY, '0);  // doorbell
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_NOTIFY, 32'h1); // other queue
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_QUEUE_SEL, 32'h1);
      add_item(vmbrf_pkg::REQ_READ, vmbrf_pkg::OFF_QUEUE_MAX, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_DESC_LO, '1);       // ignored, queue 1
      add_item(vmbrf_pkg::REQ_COMPLETE, vmbrf_pkg::OFF_STATUS, '1);
      add_item(REQ_SPARE, vmbrf_pkg::OFF_STATUS, 32'h0);                // no effect
      add_item(vmbrf_pkg::REQ_READ, 12'hFFF, '0);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_IRQ_ACK, '1);
      add_item(vmbrf_pkg::REQ_WRITE, vmbrf_pkg::OFF_STATUS, '0);        // full device reset
      wait_drained();

      // random phases, each under its own configuration
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin cap_val = '1; feat_val = '1; end
            1: begin cap_val = '0; feat_val = '0; end
            2: begin cap_val = {$urandom, $urandom}; feat_val = {$urandom, $urandom}; end
            default: begin
               cap_val = {$urandom, $urandom};
               feat_val = vmbrf_pkg::OFFERED_RESET | 64'($urandom);
            end
         endcase
         write_setting(vmbrf_pkg::CSR_CAPACITY, cap_val);
         write_setting(vmbrf_pkg::CSR_OFFERED, feat_val);
         phase_start = queued_count;
         while (queued_count - phase_start < PHASE_ITEMS) begin
            chunk_end = queued_count + $urandom_range(20, 45);
            while (queued_count < chunk_end) begin
               case ($urandom_range(0, 9))
                  0:          add_bringup();
                  1, 2, 3, 4: add_traffic();
                  default:    add_noise();
               endcase
            end
            wait_drained();
         end
      end

      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("virtio_mmio_block_register_file_unit_tb OK");
      end else begin
         $display("virtio_mmio_block_register_file_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== virtio_mmio_block_register_file_unit.f =====
rtl/vmbrf_pkg.sv
rtl/vmbrf_if.sv
rtl/vmbrf_regs.sv
rtl/virtio_mmio_block_register_file_unit.sv
rtl/vmbrf_checker.sv
sim/virtio_mmio_block_register_file_unit_tb.sv
